// File: hdl/sact_pkg.sv
// Shared types and constants for the set-associative cache tag model.
package sact_pkg;

    localparam int CNT_W = 32;
    localparam int CFG_W = 4;
    localparam int MAX_OFFSET = 12;

    typedef enum logic [1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_SET_BITS    = 2'd1,
        CFG_WAYS        = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic        action;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic        wrote_back;
        logic [2:0]  way;
        logic [31:0] access_count;
        logic [31:0] read_count;
        logic [31:0] write_count;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] eviction_count;
        logic [31:0] writeback_count;
    } t_rsp;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
    } t_status;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

// File: hdl/sact_ctrl.sv
// Controller state machine for the cache tag model.
module sact_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  sact_pkg::t_status i_status,
    output sact_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    sact_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sact_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            sact_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = sact_pkg::ST_LOOKUP;
                end
            end
            sact_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) n_state = sact_pkg::ST_IDLE;
            end
            sact_pkg::ST_LOOKUP: begin
                n_state = sact_pkg::ST_UPDATE;
            end
            sact_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = sact_pkg::ST_IDLE;
            end
            default: n_state = sact_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: hdl/sact_dp.sv
// Datapath: set memories, lookup, replacement choice and counters.
module sact_dp #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS     = 8,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sact_pkg::t_cmd        i_cmd,
    input  sact_pkg::t_req        i_req,
    input  logic [3:0]            i_offset_bits,
    input  logic [3:0]            i_set_bits,
    input  logic [3:0]            i_ways,
    output sact_pkg::t_status     o_status,
    output logic                  o_valid,
    output sact_pkg::t_rsp        o_rsp
);

    localparam int SETS = 1 << MAX_SET_BITS;
    localparam int SW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TW   = ADDRESS_BITS;

    typedef logic [MAX_WAYS-1:0][TW-1:0] t_tags;
    typedef struct packed {
        logic [MAX_WAYS-1:0] valid;
        logic [MAX_WAYS-1:0] dirty;
        logic [MAX_WAYS-1:0] mru;
    } t_marks;

    t_tags  tag_mem  [SETS];
    t_marks mark_mem [SETS];

    t_tags         r_tags;
    t_marks        r_marks;
    logic [SW-1:0] r_set;
    logic [TW-1:0] r_tag;
    logic          r_write;
    logic [SW:0]   r_clr;
    logic [WW:0]   r_nw;

    logic [sact_pkg::CNT_W-1:0] r_acc, r_rd, r_wr, r_hit, r_miss, r_ev, r_wb;
    logic          r_valid;
    logic          r_o_hit, r_o_ev, r_o_wb;
    logic [2:0]    r_o_way;

    logic [3:0]    ob, sb;
    logic [TW-1:0] addr, set_full, tag_c;
    logic [4:0]    shamt;

    always_comb begin
        ob = (i_offset_bits > 4'(sact_pkg::MAX_OFFSET)) ? 4'(sact_pkg::MAX_OFFSET)
                                                        : i_offset_bits;
        sb = (32'(i_set_bits) > 32'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : i_set_bits;
        addr = TW'(i_req.address);
        shamt = 5'(ob) + 5'(sb);
        set_full = (addr >> ob) & ~({TW{1'b1}} << sb);
        tag_c = addr >> shamt;
    end

    assign o_status.clr_done = (r_clr == (SW+1)'(SETS - 1));

    // lookup on registered set contents
    logic [MAX_WAYS-1:0] m_hit, m_inv, m_nr, en;
    logic [WW-1:0] w_hit, w_inv, w_nr, w_sel;
    logic any_hit, any_inv, any_nr, ev, wb;
    t_marks nm;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            en[w]    = (w < r_nw);
            m_hit[w] = en[w] && r_marks.valid[w] && (r_tags[w] == r_tag);
            m_inv[w] = en[w] && !r_marks.valid[w];
            m_nr[w]  = en[w] && !r_marks.mru[w];
        end
        w_hit = '0; w_inv = '0; w_nr = '0;
        for (int w = MAX_WAYS-1; w >= 0; w--) begin
            if (m_hit[w]) w_hit = WW'(w);
            if (m_inv[w]) w_inv = WW'(w);
            if (m_nr[w])  w_nr  = WW'(w);
        end
        any_hit = |m_hit; any_inv = |m_inv; any_nr = |m_nr;
        nm = r_marks;
        ev = 1'b0;
        wb = 1'b0;
        if (any_hit) begin
            w_sel = w_hit;
            nm.mru[w_hit] = 1'b1;
            if (r_write) nm.dirty[w_hit] = 1'b1;
        end else begin
            if (any_inv) begin
                w_sel = w_inv;
            end else begin
                ev = 1'b1;
                if (any_nr) begin
                    w_sel = w_nr;
                end else begin
                    w_sel = '0;
                    nm.mru = r_marks.mru & ~en;
                end
                wb = r_marks.dirty[w_sel];
            end
            nm.valid[w_sel] = 1'b1;
            nm.dirty[w_sel] = r_write;
            nm.mru[w_sel]   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mark_mem[r_clr[SW-1:0]] <= '0;
        end else if (i_cmd.update) begin
            mark_mem[r_set] <= nm;
            if (!any_hit) tag_mem[r_set][w_sel] <= r_tag;
        end
        r_tags  <= tag_mem[r_set];
        r_marks <= mark_mem[r_set];
        if (i_cmd.capture) begin
            r_set   <= SW'(set_full);
            r_tag   <= tag_c;
            r_write <= i_req.action;
            r_nw    <= (i_ways == 4'd0) ? (WW+1)'(1)
                     : (32'(i_ways) > 32'(MAX_WAYS)) ? (WW+1)'(MAX_WAYS)
                     : (WW+1)'(i_ways);
        end
        r_o_hit <= any_hit;
        r_o_ev  <= ev;
        r_o_wb  <= wb;
        r_o_way <= 3'(w_sel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_valid <= 1'b0;
            {r_acc, r_rd, r_wr, r_hit, r_miss, r_ev, r_wb} <= '0;
        end else begin
            r_valid <= i_cmd.update;
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.update) begin
                r_acc <= sact_pkg::sat_inc(r_acc);
                if (r_write) r_wr <= sact_pkg::sat_inc(r_wr);
                else         r_rd <= sact_pkg::sat_inc(r_rd);
                if (any_hit) r_hit  <= sact_pkg::sat_inc(r_hit);
                else         r_miss <= sact_pkg::sat_inc(r_miss);
                if (ev) r_ev <= sact_pkg::sat_inc(r_ev);
                if (wb) r_wb <= sact_pkg::sat_inc(r_wb);
            end
        end
    end

    assign o_valid = r_valid;
    always_comb begin
        o_rsp.hit             = r_o_hit;
        o_rsp.evicted         = r_o_ev;
        o_rsp.wrote_back      = r_o_wb;
        o_rsp.way             = r_o_way;
        o_rsp.access_count    = r_acc;
        o_rsp.read_count      = r_rd;
        o_rsp.write_count     = r_wr;
        o_rsp.hit_count       = r_hit;
        o_rsp.miss_count      = r_miss;
        o_rsp.eviction_count  = r_ev;
        o_rsp.writeback_count = r_wb;
    end

endmodule

// File: hdl/set_assoc_cache_tag_model_top.sv
// Top level of the set-associative write-back cache tag model.
//   channel  | handshake                 | payload
//   request  | i_start, o_busy           | i_req (action, address)
//   result   | o_done strobe, one cycle  | o_rsp (outcome, counters)
//   config   | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
// Busy is high after the start beat, through the read of the set memory and then
// its read-modify-write. The done strobe follows in the next cycle, and a new
// access is taken only once busy has fallen again.
// After reset a pass clearing all 2**MAX_SET_BITS sets (1024) holds busy high.
// The receiver cannot stall; each result is shown for one cycle.
module set_assoc_cache_tag_model_top #(
    parameter int MAX_SET_BITS = 10,
    parameter int MAX_WAYS     = 8,
    parameter int ADDRESS_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  sact_pkg::t_req i_req,
    output logic           o_done,
    output sact_pkg::t_rsp o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [3:0]     i_cfg_data
);

    sact_pkg::t_cmd    cmd;
    sact_pkg::t_status status;
    logic [3:0] r_ob, r_sb, r_nw;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob <= 4'd6;
            r_sb <= 4'd4;
            r_nw <= 4'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sact_pkg::CFG_OFFSET_BITS: r_ob <= i_cfg_data;
                sact_pkg::CFG_SET_BITS:    r_sb <= i_cfg_data;
                sact_pkg::CFG_WAYS:        r_nw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sact_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start,
        .i_status(status), .o_cmd(cmd), .o_busy
    );

    sact_dp #(
        .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS), .ADDRESS_BITS(ADDRESS_BITS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_req,
        .i_offset_bits(r_ob), .i_set_bits(r_sb), .i_ways(r_nw),
        .o_status(status), .o_valid(o_done), .o_rsp
    );

endmodule
